// File: sv/bsp_pkg.sv
// Shared constants, types and fixed-point helpers for the Boy's surface point evaluator.
`default_nettype none
package bsp_pkg;

    localparam int IN_W           = 16;
    localparam int OUT_W          = 24;
    localparam int ANGLE_BITS_DEF = 15;
    localparam int FRAC_BITS_DEF  = 16;

    // Working word: Q28 with headroom for the polynomial terms.
    localparam int QW           = 34;
    localparam int WORK_FRAC    = 28;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int POLY_LAT     = 7;
    localparam int PIPE_LAT     = CORDIC_LAT + POLY_LAT;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    typedef logic signed [QW-1:0] t_q;

    localparam t_q CORDIC_START = 34'sd652032874;
    localparam t_q SQRT3_HALF   = 34'sd232471924;

    // Rotation angles of the CORDIC steps, 2^32 standing for 2*pi.
    localparam t_q ATAN_PHASE [CORDIC_STEPS] = '{
        34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
        34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2F,
        34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA,
        34'sh0000517D, 34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
        34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051, 34'sh00000029,
        34'sh00000014, 34'sh0000000A, 34'sh00000005, 34'sh00000003, 34'sh00000001
    };

    // Q28 product, floor of the exact product.
    function automatic t_q qmul(input t_q a, input t_q b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return t_q'(p[WORK_FRAC +: QW]);
    endfunction

endpackage
`default_nettype wire

// File: sv/bsp_if.sv
// Valid/ready channel interfaces for the angle input words and the point output words.
`default_nettype none
interface bsp_in_if;
    logic                          valid;
    logic                          ready;
    logic [bsp_pkg::IN_W-1:0]      angle_u;
    logic [bsp_pkg::IN_W-1:0]      angle_v;

    modport source (output valid, output angle_u, output angle_v, input ready);
    modport sink   (input valid, input angle_u, input angle_v, output ready);
endinterface

interface bsp_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [bsp_pkg::OUT_W-1:0] x_coord;
    logic signed [bsp_pkg::OUT_W-1:0] y_coord;
    logic signed [bsp_pkg::OUT_W-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface
`default_nettype wire

// File: sv/boys_surface_point_eval_core.sv
// Top level of the Boy's surface point evaluator: two CORDIC pipelines and the polynomial pipeline.
// Takes one (u, v) angle word per cycle and returns one (x, y, z) point word per cycle while the
// output is taken. The CORDIC pipelines have one stage per rotation step plus entry and exit and
// feed the polynomial pipeline. The whole pipeline advances together; when the output word is
// not taken it holds, and input ready drops only while a finished word waits.
`default_nettype none
module boys_surface_point_eval_core #(
    parameter int ANGLE_BITS = bsp_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = bsp_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsp_in_if.sink    i_in,
    bsp_out_if.source o_out
);
    import bsp_pkg::*;

    logic [PIPE_LAT-1:0] r_vld;
    logic                w_en;
    t_q                  su, cu, sv, cv;

    assign w_en        = !r_vld[PIPE_LAT-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in.valid};
        end
    end

    bsp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_u (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_code (i_in.angle_u),
        .o_sin  (su),
        .o_cos  (cu)
    );

    bsp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_v (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_code (i_in.angle_v),
        .o_sin  (sv),
        .o_cos  (cv)
    );

    bsp_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_su  (su),
        .i_cu  (cu),
        .i_sv  (sv),
        .i_cv  (cv),
        .o_x   (o_out.x_coord),
        .o_y   (o_out.y_coord),
        .o_z   (o_out.z_coord)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output word stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted word did not enter the pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_out.valid)
        else $error("output valid right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (r_vld == $past(r_vld)))
        else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

// File: sv/bsp_cordic.sv
// Pipelined rotation-mode CORDIC giving sin and cos in Q28 of an angle code.
`default_nettype none
module bsp_cordic #(
    parameter int ANGLE_BITS = bsp_pkg::ANGLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [bsp_pkg::IN_W-1:0] i_code,
    output bsp_pkg::t_q             o_sin,
    output bsp_pkg::t_q             o_cos
);
    import bsp_pkg::*;

    localparam int SH = 31 - ANGLE_BITS;

    logic [47:0] code_ext;
    logic [31:0] phase_raw;
    logic [31:0] phase_qtr;
    logic [31:0] phase_adj;
    logic        flip_c;
    t_q          z_c;

    t_q   r_x    [0:CORDIC_STEPS];
    t_q   r_y    [0:CORDIC_STEPS];
    t_q   r_z    [0:CORDIC_STEPS];
    logic r_flip [0:CORDIC_STEPS];
    t_q   r_sin;
    t_q   r_cos;

    // Angles in the left half plane are rotated by pi and the result negated.
    always_comb begin
        code_ext  = 48'(i_code) << SH;
        phase_raw = code_ext[31:0];
        phase_qtr = phase_raw + 32'h4000_0000;
        flip_c    = phase_qtr[31];
        phase_adj = flip_c ? (phase_raw + 32'h8000_0000) : phase_raw;
        z_c       = QW'(signed'(phase_adj));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CORDIC_START;
            r_y[0]    <= '0;
            r_z[0]    <= z_c;
            r_flip[0] <= flip_c;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][QW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ATAN_PHASE[i];
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ATAN_PHASE[i];
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= (r_flip[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS]) >>> 2;
            r_sin <= (r_flip[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS]) >>> 2;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

// File: sv/bsp_poly.sv
// Pipelined evaluation of the x, y and z polynomials and the output formatting.
`default_nettype none
module bsp_poly #(
    parameter int FRAC_BITS = bsp_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  bsp_pkg::t_q                      i_su,
    input  bsp_pkg::t_q                      i_cu,
    input  bsp_pkg::t_q                      i_sv,
    input  bsp_pkg::t_q                      i_cv,
    output logic signed [bsp_pkg::OUT_W-1:0] o_x,
    output logic signed [bsp_pkg::OUT_W-1:0] o_y,
    output logic signed [bsp_pkg::OUT_W-1:0] o_z
);
    import bsp_pkg::*;

    localparam int FW   = QW + 3;
    localparam int SH_R = (FRAC_BITS < WORK_FRAC) ? (WORK_FRAC - FRAC_BITS) : 1;
    localparam int SH_L = (FRAC_BITS > WORK_FRAC) ? (FRAC_BITS - WORK_FRAC) : 0;
    localparam logic signed [FW-1:0] SAT_HI = FW'(OUT_MAX);
    localparam logic signed [FW-1:0] SAT_LO = FW'(OUT_MIN);
    localparam logic signed [FW-1:0] HALF   = FW'(1) <<< (SH_R - 1);

    // Q28 to output scale, rounding half up, then saturation.
    function automatic logic signed [OUT_W-1:0] fmt(input t_q v);
        logic signed [FW-1:0] w;
        if (FRAC_BITS < WORK_FRAC) begin
            w = (FW'(v) + HALF) >>> SH_R;
        end else begin
            w = FW'(v) <<< SH_L;
        end
        if (w > SAT_HI) begin
            w = SAT_HI;
        end else if (w < SAT_LO) begin
            w = SAT_LO;
        end
        return w[OUT_W-1:0];
    endfunction

    t_q r_a, r_b, r_c;
    t_q r_p2_a2, r_p2_b2, r_p2_c2, r_p2_ab, r_p2_bc, r_p2_ac;
    t_q r_p2_sum, r_p2_d1, r_p2_d2, r_p2_d3;
    t_q r_p3_s2, r_p3_t1, r_p3_eac, r_p3_ebc, r_p3_ecb, r_p3_eab;
    t_q r_p3_ss, r_p3_pp, r_p3_ab, r_p3_bc, r_p3_ac, r_p3_sum, r_p3_d3;
    t_q r_p4_m1, r_p4_m2, r_p4_m3, r_p4_m4, r_p4_m5, r_p4_m6;
    t_q r_p4_s3, r_p4_p, r_p4_sum;
    t_q r_p5_x, r_p5_y, r_p5_z, r_p5_sum;
    t_q r_p6_x, r_p6_y, r_p6_z;
    logic signed [OUT_W-1:0] r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= qmul(i_su, i_sv);
            r_b <= qmul(i_cu, i_sv);
            r_c <= i_cv;

            r_p2_a2  <= qmul(r_a, r_a);
            r_p2_b2  <= qmul(r_b, r_b);
            r_p2_c2  <= qmul(r_c, r_c);
            r_p2_ab  <= qmul(r_a, r_b);
            r_p2_bc  <= qmul(r_b, r_c);
            r_p2_ac  <= qmul(r_a, r_c);
            r_p2_sum <= r_a + r_b + r_c;
            r_p2_d1  <= r_a - r_b;
            r_p2_d2  <= r_c - r_a;
            r_p2_d3  <= r_b - r_c;

            r_p3_s2  <= r_p2_a2 + r_p2_b2 + r_p2_c2;
            r_p3_t1  <= (r_p2_b2 <<< 1) - r_p2_a2 - r_p2_c2;
            r_p3_eac <= r_p2_a2 - r_p2_c2;
            r_p3_ebc <= r_p2_b2 - r_p2_c2;
            r_p3_ecb <= r_p2_c2 - r_p2_b2;
            r_p3_eab <= r_p2_a2 - r_p2_b2;
            r_p3_ss  <= qmul(r_p2_sum, r_p2_sum);
            r_p3_pp  <= qmul(r_p2_d1, r_p2_d2);
            r_p3_ab  <= r_p2_ab;
            r_p3_bc  <= r_p2_bc;
            r_p3_ac  <= r_p2_ac;
            r_p3_sum <= r_p2_sum;
            r_p3_d3  <= r_p2_d3;

            r_p4_m1  <= qmul(r_p3_t1, r_p3_s2);
            r_p4_m2  <= qmul(r_p3_ac, r_p3_eac);
            r_p4_m3  <= qmul(r_p3_bc, r_p3_ebc);
            r_p4_m4  <= qmul(r_p3_ab, r_p3_eab);
            r_p4_m5  <= qmul(r_p3_eac, r_p3_s2);
            r_p4_m6  <= qmul(r_p3_bc, r_p3_ecb);
            r_p4_s3  <= qmul(r_p3_ss, r_p3_sum);
            r_p4_p   <= qmul(r_p3_pp, r_p3_d3);
            r_p4_sum <= r_p3_sum;

            r_p5_x   <= (r_p4_m1 + (r_p4_m2 <<< 1) + r_p4_m3 + r_p4_m4) >>> 1;
            r_p5_y   <= r_p4_m5 + r_p4_m6 + r_p4_m4;
            r_p5_z   <= r_p4_s3 + (r_p4_p <<< 2);
            r_p5_sum <= r_p4_sum;

            r_p6_x <= r_p5_x;
            r_p6_y <= qmul(r_p5_y, SQRT3_HALF);
            r_p6_z <= qmul(r_p5_sum, r_p5_z) >>> 3;

            r_x <= fmt(r_p6_x);
            r_y <= fmt(r_p6_y);
            r_z <= fmt(r_p6_z);
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire
